// File: design/lfsri_pkg.sv
`default_nettype none

package lfsri_pkg;

   localparam int LED_COUNT_DEF = 64;

   localparam int KIND_W       = 3;
   localparam int IDX_W        = 6;
   localparam int AMT_W        = 6;
   localparam int CH_W         = 8;
   localparam int PX_W         = 3 * CH_W;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 24;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE      = 3'd0,
      KIND_READ       = 3'd1,
      KIND_SHIFT_UP   = 3'd2,
      KIND_SHIFT_DN   = 3'd3,
      KIND_ROT_DN     = 3'd4,
      KIND_ROT_UP     = 3'd5,
      KIND_INV_ONE    = 3'd6,
      KIND_INV_ALL    = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_COPY,
      ST_MOVE,
      ST_INV_ALL,
      ST_DONE
   } state_type;

   // Source lookup result handed from the address unit to the sequencer.
   typedef struct packed {
      logic black;
   } move_flags_type;

   // Channel-wise full-scale minus level, wrapping at 8 bits.
   function automatic logic [PX_W-1:0] invert_px(input logic [PX_W-1:0] px,
                                                  input logic [CH_W-1:0] mx);
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
      r = mx - px[23:16];
      g = mx - px[15:8];
      b = mx - px[7:0];
      return {r, g, b};
   endfunction

endpackage

`default_nettype wire

// File: design/led_frame_shift_rotate_invert.sv
// Path from accept to result word: write or ignored move go straight to DONE; read and
// invert one pass through PIX_RD and PIX_WR; invert all makes an INV_ALL pass; shift and
// rotate make a COPY pass, then a MOVE pass. One command at a time; the next word is taken
// in the cycle after the result is loaded. Shift and rotate pass the frame twice through
// one read and one write port. Reset: synchronous; the frame store is cleared to black by
// a sweep over every pixel, during which req_tready stays low. channel_max resets to 255.
`default_nettype none

module led_frame_shift_rotate_invert #(
   parameter int LED_COUNT = lfsri_pkg::LED_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Command channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // pixel_index[5:0], amount[11:6], red_in[19:12], green_in[27:20], blue_in[35:28]
   input  wire logic [lfsri_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // kind[2:0]
   input  wire logic [lfsri_pkg::KIND_W-1:0]        req_tuser,
   // Result channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic      [lfsri_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // ignored[0]
   output logic      [0:0]                          rsp_tuser,
   // channel_max write.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lfsri_pkg::CH_W-1:0]          csr_data
);

   localparam int AW = $clog2(LED_COUNT);
   localparam int CW = AW + 1;
   localparam int IW = (CW > lfsri_pkg::IDX_W) ? CW : lfsri_pkg::IDX_W;
   localparam logic [CW-1:0] NC = CW'(LED_COUNT);
   localparam logic [IW-1:0] NI = IW'(LED_COUNT);
   localparam int PXW = lfsri_pkg::PX_W;

   // ---------------------------------------------------------------- request decode
   lfsri_pkg::kind_type               req_kind;
   logic [lfsri_pkg::IDX_W-1:0]       req_idx;
   logic [lfsri_pkg::AMT_W-1:0]       req_amt;
   logic [PXW-1:0]                    req_rgb;
   logic [IW-1:0]                     req_idx_ext;
   logic [IW-1:0]                     req_amt_ext;
   logic                              req_idx_ok;
   logic                              req_amt_bad;

   assign req_kind    = lfsri_pkg::kind_type'(req_tuser);
   assign req_idx     = req_tdata[5:0];
   assign req_amt     = req_tdata[11:6];
   assign req_rgb     = {req_tdata[19:12], req_tdata[27:20], req_tdata[35:28]};
   assign req_idx_ext = IW'(req_idx);
   assign req_amt_ext = IW'(req_amt);
   assign req_idx_ok  = (req_idx_ext < NI);
   // Zero or out-of-frame amounts leave the frame alone and flag the result.
   assign req_amt_bad = (req_amt_ext == '0) || (req_amt_ext >= NI);

   // ---------------------------------------------------------------- registers
   lfsri_pkg::state_type        state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   lfsri_pkg::kind_type         kind_ff, kind_in;
   logic [lfsri_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                        idx_ok_ff, idx_ok_in;
   logic [CW-1:0]               amt_ff, amt_in;
   logic                        blk_ff, blk_in;
   logic [PXW-1:0]              res_px_ff, res_px_in;
   logic                        res_ign_ff, res_ign_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [PXW-1:0]              rsp_px_ff, rsp_px_in;
   logic                        rsp_ign_ff, rsp_ign_in;
   logic [lfsri_pkg::CH_W-1:0]  cmax_ff, cmax_in;

   // ---------------------------------------------------------------- memory ports
   logic           st_we;
   logic [AW-1:0]  st_waddr;
   logic [PXW-1:0] st_wdata;
   logic [AW-1:0]  st_raddr;
   logic [PXW-1:0] st_rdata;
   logic           sc_we;
   logic [PXW-1:0] sc_rdata;

   logic [CW-1:0]  cnt_m1;
   logic [AW-1:0]  wr_pos;
   logic [IW-1:0]  idx_ext;
   logic [AW-1:0]  idx_addr;
   logic           pass_end;

   logic [AW-1:0]               src;
   lfsri_pkg::move_flags_type   mflags;

   assign cnt_m1   = cnt_ff - CW'(1);
   // Writes go to the previous position because of the registered read port.
   assign wr_pos   = cnt_m1[AW-1:0];
   assign idx_ext  = IW'(idx_ff);
   assign idx_addr = idx_ext[AW-1:0];
   assign pass_end = (cnt_ff == NC);

   // Frame store.
   lfsri_ram #(
      .WIDTH (PXW),
      .DEPTH (LED_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // Snapshot of the frame taken before a shift or rotate.
   lfsri_ram #(
      .WIDTH (PXW),
      .DEPTH (LED_COUNT)
   ) u_scratch (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (wr_pos),
      .wr_data (st_rdata),
      .rd_addr (src),
      .rd_data (sc_rdata)
   );

   // Shared source-position unit: one add, one subtract and two compares per pixel, plus a wrap correction for rotates.
   lfsri_move_unit #(
      .LED_COUNT (LED_COUNT)
   ) u_move (
      .kind  (kind_ff),
      .amt   (amt_ff),
      .pos   (cnt_ff[AW-1:0]),
      .src   (src),
      .flags (mflags)
   );

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfsri_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmax_ff      <= '1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cmax_ff      <= cmax_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      idx_ff     <= idx_in;
      idx_ok_ff  <= idx_ok_in;
      amt_ff     <= amt_in;
      blk_ff     <= blk_in;
      res_px_ff  <= res_px_in;
      res_ign_ff <= res_ign_in;
      rsp_px_ff  <= rsp_px_in;
      rsp_ign_ff <= rsp_ign_in;
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      idx_ok_in  = idx_ok_ff;
      amt_in     = amt_ff;
      blk_in     = blk_ff;
      res_px_in  = res_px_ff;
      res_ign_in = res_ign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_px_in  = rsp_px_ff;
      rsp_ign_in = rsp_ign_ff;
      cmax_in    = (csr_valid && csr_ready) ? csr_data : cmax_ff;

      req_tready = 1'b0;
      st_we      = 1'b0;
      st_waddr   = wr_pos;
      st_wdata   = '0;
      st_raddr   = cnt_ff[AW-1:0];
      sc_we      = 1'b0;

      case (state_ff)
         lfsri_pkg::ST_CLEAR: begin
            // Sweep the store to black, one pixel per cycle.
            st_we    = 1'b1;
            st_waddr = cnt_ff[AW-1:0];
            if (cnt_ff == NC - CW'(1)) begin
               cnt_in   = '0;
               state_in = lfsri_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         lfsri_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in    = req_kind;
               idx_in     = req_idx;
               idx_ok_in  = req_idx_ok;
               amt_in     = req_amt_ext[CW-1:0];
               res_px_in  = '0;
               res_ign_in = 1'b0;
               cnt_in     = '0;
               if (req_kind inside {lfsri_pkg::KIND_SHIFT_UP, lfsri_pkg::KIND_SHIFT_DN,
                                    lfsri_pkg::KIND_ROT_DN, lfsri_pkg::KIND_ROT_UP}) begin
                  if (req_amt_bad) begin
                     res_ign_in = 1'b1;
                     state_in   = lfsri_pkg::ST_DONE;
                  end else begin
                     state_in = lfsri_pkg::ST_COPY;
                  end
               end else begin
                  case (req_kind)
                     lfsri_pkg::KIND_WRITE: begin
                        // Write straight from the request word.
                        st_we    = req_idx_ok;
                        st_waddr = req_idx_ext[AW-1:0];
                        st_wdata = req_rgb;
                        state_in = lfsri_pkg::ST_DONE;
                     end
                     lfsri_pkg::KIND_INV_ALL: begin
                        state_in = lfsri_pkg::ST_INV_ALL;
                     end
                     default: begin
                        // Read and invert one both fetch the pixel first.
                        state_in = lfsri_pkg::ST_PIX_RD;
                     end
                  endcase
               end
            end
         end
         lfsri_pkg::ST_PIX_RD: begin
            st_raddr = idx_addr;
            state_in = lfsri_pkg::ST_PIX_WR;
         end
         lfsri_pkg::ST_PIX_WR: begin
            if (kind_ff == lfsri_pkg::KIND_READ) begin
               res_px_in = idx_ok_ff ? st_rdata : '0;
            end else begin
               st_we    = idx_ok_ff;
               st_waddr = idx_addr;
               st_wdata = lfsri_pkg::invert_px(st_rdata, cmax_ff);
            end
            state_in = lfsri_pkg::ST_DONE;
         end
         lfsri_pkg::ST_COPY: begin
            // Stream the store into the snapshot.
            sc_we = (cnt_ff != '0);
            if (pass_end) begin
               cnt_in   = '0;
               state_in = lfsri_pkg::ST_MOVE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         lfsri_pkg::ST_MOVE: begin
            // Fetch the source pixel for this position; write the previous one back.
            blk_in   = mflags.black;
            st_we    = (cnt_ff != '0);
            st_wdata = blk_ff ? '0 : sc_rdata;
            if (pass_end) begin
               cnt_in   = '0;
               state_in = lfsri_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         lfsri_pkg::ST_INV_ALL: begin
            // Read pixel i while writing back inverted pixel i-1.
            st_we    = (cnt_ff != '0);
            st_wdata = lfsri_pkg::invert_px(st_rdata, cmax_ff);
            if (pass_end) begin
               cnt_in   = '0;
               state_in = lfsri_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         lfsri_pkg::ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_px_in    = res_px_ff;
               rsp_ign_in   = res_ign_ff;
               state_in     = lfsri_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfsri_pkg::ST_IDLE;
         end
      endcase
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_px_ff[7:0], rsp_px_ff[15:8], rsp_px_ff[23:16]};
   assign rsp_tuser  = rsp_ign_ff;

endmodule

`default_nettype wire

// File: design/lfsri_ram.sv
`default_nettype none

module lfsri_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/lfsri_move_unit.sv
`default_nettype none

module lfsri_move_unit #(
   parameter int LED_COUNT = lfsri_pkg::LED_COUNT_DEF
) (
   input  wire lfsri_pkg::kind_type               kind,
   input  wire logic [$clog2(LED_COUNT):0]        amt,
   input  wire logic [$clog2(LED_COUNT)-1:0]      pos,
   output logic      [$clog2(LED_COUNT)-1:0]      src,
   output lfsri_pkg::move_flags_type              flags
);

   localparam int AW = $clog2(LED_COUNT);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] NC = CW'(LED_COUNT);

   logic [CW-1:0] pos_e;
   logic [CW-1:0] sum;
   logic [CW-1:0] dif;
   logic [CW-1:0] src_full;
   logic          lt;
   logic          ge;

   assign pos_e = {1'b0, pos};
   assign sum   = pos_e + amt;
   assign dif   = pos_e - amt;
   assign lt    = (pos_e < amt);
   assign ge    = (sum >= NC);

   always_comb begin
      src_full    = pos_e;
      flags.black = 1'b0;
      case (kind)
         lfsri_pkg::KIND_SHIFT_UP: begin
            src_full    = dif;
            flags.black = lt;
         end
         lfsri_pkg::KIND_SHIFT_DN: begin
            src_full    = sum;
            flags.black = ge;
         end
         lfsri_pkg::KIND_ROT_DN: begin
            src_full   = ge ? (sum - NC) : sum;
         end
         lfsri_pkg::KIND_ROT_UP: begin
            src_full   = lt ? (dif + NC) : dif;
         end
         default: begin
            src_full = pos_e;
         end
      endcase
   end

   assign src = src_full[AW-1:0];

endmodule

`default_nettype wire

// File: dv/led_frame_shift_rotate_invert_checker.sv
`timescale 1ns / 1ps

module led_frame_shift_rotate_invert_checker
   import lfsri_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   // pixel_index[5:0], amount[11:6], red_in[19:12], green_in[27:20], blue_in[35:28]
   input  wire logic [REQ_TDATA_W-1:0]   req_tdata,
   // kind[2:0]
   input  wire logic [KIND_W-1:0]        req_tuser,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   input  wire logic [RSP_TDATA_W-1:0]   rsp_tdata,
   // ignored[0]
   input  wire logic [0:0]               rsp_tuser,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CH_W-1:0]          csr_data,
   output int                            fail_count,
   output int                            pending_count
);

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  pixel;
      logic [AMT_W-1:0]  amount;
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
   } led_cmd_t;

   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic              ignored;
   } led_reply_t;

   logic [PX_W-1:0] frame_model [LED_COUNT];
   logic [CH_W-1:0] level_max = 8'hFF;
   led_reply_t      reply_q [$];
   int              errors = 0;
   int              pending = 0;

   assign fail_count    = errors;
   assign pending_count = pending;

   task automatic flag_error(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   // Full scale minus level per channel, 8-bit wrap.
   function automatic logic [PX_W-1:0] complement_px(input logic [PX_W-1:0] px);
      logic [PX_W-1:0] res;
      for (int c = 0; c < 3; c++)
         res[c*CH_W +: CH_W] = level_max - px[c*CH_W +: CH_W];
      return res;
   endfunction

   function automatic led_reply_t run_command(input led_cmd_t cmd);
      led_reply_t      reply;
      logic [PX_W-1:0] snap [LED_COUNT];
      logic [PX_W-1:0] px;
      int              n;
      reply = '0;
      n = int'(cmd.amount);
      case (cmd.kind)
         KIND_WRITE: begin
            if (cmd.pixel < LED_COUNT)
               frame_model[cmd.pixel] = {cmd.red, cmd.green, cmd.blue};
         end
         KIND_READ: begin
            if (cmd.pixel < LED_COUNT) begin
               px = frame_model[cmd.pixel];
               reply.red   = px[23:16];
               reply.green = px[15:8];
               reply.blue  = px[7:0];
            end
         end
         KIND_SHIFT_UP, KIND_SHIFT_DN, KIND_ROT_DN, KIND_ROT_UP: begin
            if (n == 0 || n >= LED_COUNT) begin
               reply.ignored = 1'b1;
            end else begin
               snap = frame_model;
               for (int i = 0; i < LED_COUNT; i++) begin
                  case (cmd.kind)
                     KIND_SHIFT_UP: frame_model[i] = (i >= n) ? snap[i-n] : '0;
                     KIND_SHIFT_DN: frame_model[i] = (i + n < LED_COUNT) ? snap[i+n] : '0;
                     KIND_ROT_DN:   frame_model[i] = snap[(i + n) % LED_COUNT];
                     default:       frame_model[i] = snap[(i + LED_COUNT - n) % LED_COUNT];
                  endcase
               end
            end
         end
         KIND_INV_ONE: begin
            if (cmd.pixel < LED_COUNT)
               frame_model[cmd.pixel] = complement_px(frame_model[cmd.pixel]);
         end
         default: begin
            for (int i = 0; i < LED_COUNT; i++)
               frame_model[i] = complement_px(frame_model[i]);
         end
      endcase
      return reply;
   endfunction

   task automatic check_field(input string name, input logic [CH_W-1:0] want,
                              input logic [CH_W-1:0] got);
      if (got !== want)
         flag_error($sformatf("%s expected %h got %h", name, want, got));
   endtask

   always @(posedge clock) begin
      led_cmd_t   cmd;
      led_reply_t want;
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++)
            frame_model[i] = '0;
         level_max = 8'hFF;
         reply_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            level_max = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               flag_error($sformatf("result word %h/%b with nothing outstanding",
                                    rsp_tdata, rsp_tuser));
            end else begin
               want = reply_q.pop_front();
               check_field("red_out", want.red, rsp_tdata[7:0]);
               check_field("green_out", want.green, rsp_tdata[15:8]);
               check_field("blue_out", want.blue, rsp_tdata[23:16]);
               check_field("ignored", {7'd0, want.ignored}, {7'd0, rsp_tuser[0]});
            end
         end
         if (req_tvalid && req_tready) begin
            cmd.kind   = kind_type'(req_tuser);
            cmd.pixel  = req_tdata[5:0];
            cmd.amount = req_tdata[11:6];
            cmd.red    = req_tdata[19:12];
            cmd.green  = req_tdata[27:20];
            cmd.blue   = req_tdata[35:28];
            reply_q.push_back(run_command(cmd));
         end
      end
      pending = reply_q.size();
   end

endmodule

// File: dv/tb_led_frame_shift_rotate_invert.sv
`timescale 1ns / 1ps

module tb_led_frame_shift_rotate_invert;
   import lfsri_pkg::*;

   localparam int HOLD_CYCLES = 300;   // receiver hold-off, long enough to back up the input

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // pixel_index[5:0], amount[11:6], red_in[19:12], green_in[27:20], blue_in[35:28]
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   // kind[2:0]
   logic [KIND_W-1:0]        req_tuser = KIND_WRITE;

   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   // ignored[0]
   logic [0:0]               rsp_tuser;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CH_W-1:0]          csr_data = 8'hFF;

   int                       fail_count;
   int                       pending_count;

   // Traffic shaping knobs for the sender and the receiver.
   bit                       tx_steady = 1'b0;
   bit                       rx_steady = 1'b0;
   bit                       rx_hold_req = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   led_frame_shift_rotate_invert uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   led_frame_shift_rotate_invert_checker frame_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Drop valid for a random number of cycles unless the sender runs back to back.
   task automatic idle_tx();
      int n;
      n = tx_steady ? 0 : pick_gap();
      if (n > 0) begin
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Offer one command word and hold it until the block takes it. Called at a falling edge.
   task automatic send_word(input kind_type kind, input logic [IDX_W-1:0] pixel,
                            input logic [AMT_W-1:0] amount, input logic [CH_W-1:0] red,
                            input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue);
      req_tuser  = kind;
      req_tdata  = {{(REQ_TDATA_W-36){1'b0}}, blue, green, red, amount, pixel};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      idle_tx();
   endtask

   // Random command: plenty of writes and reads so the moves carry real content.
   task automatic send_random();
      int                roll;
      kind_type          kind;
      logic [AMT_W-1:0]  amount;
      roll = $urandom_range(0, 99);
      if (roll < 30)      kind = KIND_WRITE;
      else if (roll < 55) kind = KIND_READ;
      else if (roll < 62) kind = KIND_SHIFT_UP;
      else if (roll < 69) kind = KIND_SHIFT_DN;
      else if (roll < 76) kind = KIND_ROT_DN;
      else if (roll < 83) kind = KIND_ROT_UP;
      else if (roll < 92) kind = KIND_INV_ONE;
      else                kind = KIND_INV_ALL;
      // A zero amount is the ignored case; keep it rare so most moves really move.
      if ($urandom_range(0, 99) < 8)
         amount = '0;
      else
         amount = AMT_W'($urandom_range(1, 63));
      send_word(kind, IDX_W'($urandom), amount, CH_W'($urandom), CH_W'($urandom),
                CH_W'($urandom));
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register writes only with the block idle.
   task automatic write_channel_max(input logic [CH_W-1:0] level);
      drain();
      csr_data  = level;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: random stalls, steady stretches, and one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rx_hold_req = 1'b0;
         end else if (rx_steady) begin
            rsp_tready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [CH_W-1:0] levels [5];
      levels = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h80};
      levels[2] = CH_W'($urandom_range(2, 254));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of the color fields, every kind, both ends of the frame,
      // amounts at one, at the top of the range and zero for each move.
      send_word(KIND_WRITE,    6'd0,  6'd0,  8'hFF, 8'hFF, 8'hFF);
      send_word(KIND_WRITE,    6'd63, 6'd63, 8'hFF, 8'h00, 8'h5A);
      send_word(KIND_WRITE,    6'd1,  6'd0,  8'h12, 8'h34, 8'h56);
      send_word(KIND_READ,     6'd0,  6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_READ,     6'd63, 6'd0,  8'hFF, 8'hFF, 8'hFF);
      send_word(KIND_SHIFT_UP, 6'd0,  6'd1,  8'h00, 8'h00, 8'h00);
      send_word(KIND_READ,     6'd1,  6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_SHIFT_DN, 6'd0,  6'd1,  8'h00, 8'h00, 8'h00);
      send_word(KIND_ROT_UP,   6'd0,  6'd63, 8'h00, 8'h00, 8'h00);
      send_word(KIND_ROT_DN,   6'd0,  6'd63, 8'h00, 8'h00, 8'h00);
      send_word(KIND_ROT_DN,   6'd0,  6'd1,  8'h00, 8'h00, 8'h00);
      send_word(KIND_ROT_UP,   6'd0,  6'd1,  8'h00, 8'h00, 8'h00);
      // Zero amount: frame stays, ignored set.
      send_word(KIND_SHIFT_UP, 6'd5,  6'd0,  8'hAA, 8'h55, 8'hAA);
      send_word(KIND_SHIFT_DN, 6'd5,  6'd0,  8'h55, 8'hAA, 8'h55);
      send_word(KIND_ROT_DN,   6'd5,  6'd0,  8'hFF, 8'hFF, 8'hFF);
      send_word(KIND_ROT_UP,   6'd5,  6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_INV_ONE,  6'd0,  6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_READ,     6'd0,  6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_INV_ALL,  6'd0,  6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_READ,     6'd63, 6'd0,  8'h00, 8'h00, 8'h00);
      // Shift by the largest legal amount pushes all but one pixel out.
      send_word(KIND_SHIFT_UP, 6'd0,  6'd63, 8'h00, 8'h00, 8'h00);
      send_word(KIND_READ,     6'd63, 6'd0,  8'h00, 8'h00, 8'h00);
      send_word(KIND_SHIFT_DN, 6'd0,  6'd63, 8'h00, 8'h00, 8'h00);
      send_word(KIND_READ,     6'd0,  6'd0,  8'h00, 8'h00, 8'h00);

      // Random phases, one per channel_max setting.
      for (int phase = 0; phase < 5; phase++) begin
         write_channel_max(levels[phase]);
         if (phase == 2) begin
            // Back up the block: receiver holds off while the sender keeps offering.
            rx_hold_req = 1'b1;
            tx_steady   = 1'b1;
            repeat (12) send_random();
            tx_steady   = 1'b0;
            drain();
         end
         for (int n = 0; n < 80; n++) begin
            // Phase 3 opens with a stretch that has no idling on either side.
            tx_steady = (phase == 3 && n < 30);
            rx_steady = (phase == 3 && n < 30);
            send_random();
         end
         tx_steady = 1'b0;
         rx_steady = 1'b0;
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: led_frame_shift_rotate_invert.f
design/lfsri_pkg.sv
design/lfsri_ram.sv
design/lfsri_move_unit.sv
design/led_frame_shift_rotate_invert.sv
dv/led_frame_shift_rotate_invert_checker.sv
dv/tb_led_frame_shift_rotate_invert.sv
